[rtl/core/ccs_pkg.sv]
package ccs_pkg;

    localparam int CLIENTS = 16;
    localparam int CIDX_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // request kinds on s_tuser
    localparam logic [1:0] CMD_POLL    = 2'd0;
    localparam logic [1:0] CMD_CONFIRM = 2'd1;
    localparam logic [1:0] CMD_SET     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd3;

    localparam logic [7:0]  OWN_ADDR_RST = 8'd0;
    localparam logic [7:0]  GUARD_RST    = 8'd20;
    localparam logic [15:0] REPLY_RST    = 16'd100;
    localparam logic [15:0] WINDOW_RST   = 16'd10000;
    localparam logic [7:0]  ADDR_INVALID = 8'hff;
    localparam logic [2:0]  LAST_SEEN_RST = 3'd7;

    typedef enum logic [2:0] {
        CS_INIT  = 3'd0,
        CS_SKIP  = 3'd1,
        CS_GUARD = 3'd2,
        CS_REPLY = 3'd3,
        CS_DONE  = 3'd4
    } cst_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CONF,
        S_START_SCAN,
        S_WINDOW,
        S_OK_SCAN,
        S_ACT,
        S_TO_SCAN
    } fsm_t;

    typedef struct packed {
        logic tbl_wr;        // write client address table
        logic start_proc;    // new state: reload statuses, scan from slot 0
        logic scan_init_cur; // scan from the slot after the current client
        logic scan_init_zero;
        logic scan_step;
        logic use_scan;      // table read port follows the scan pointer
        logic set_cur_scan;
        logic clr_cur;
        logic conf_set_ok;
        logic emit;
        logic to_reply;
        logic to_init;
    } ccs_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       changed;
        logic       blocked;
        logic       cur_valid;
        cst_t       cur_status;
        logic       window_expired;
        logic       guard_done;
        logic       reply_done;
        logic       scan_open;
        logic       scan_last;
        logic       conf_hit;
        logic       out_free;
    } ccs_sts_t;

endpackage

[rtl/core/ccs_ctrl.sv]
module ccs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ccs_pkg::ccs_sts_t  sts,
    output ccs_pkg::ccs_cmd_t  cmd
);

    ccs_pkg::fsm_t state_reg;
    ccs_pkg::fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ccs_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ccs_pkg::S_DECODE;
                end
            end
            ccs_pkg::S_DECODE:
            begin
                case (sts.kind)
                    ccs_pkg::CMD_CONFIRM: state_next = ccs_pkg::S_CONF;
                    ccs_pkg::CMD_POLL:
                    begin
                        if (sts.changed && !sts.blocked)
                        begin
                            state_next = ccs_pkg::S_START_SCAN;
                        end
                        else
                        begin
                            state_next = ccs_pkg::S_WINDOW;
                        end
                    end
                    default: state_next = ccs_pkg::S_IDLE;
                endcase
            end
            ccs_pkg::S_CONF:
            begin
                if (sts.conf_hit || sts.scan_last)
                begin
                    state_next = ccs_pkg::S_IDLE;
                end
            end
            ccs_pkg::S_START_SCAN:
            begin
                if (sts.scan_open || sts.scan_last)
                begin
                    state_next = ccs_pkg::S_WINDOW;
                end
            end
            ccs_pkg::S_WINDOW:
            begin
                if (!sts.cur_valid || sts.window_expired)
                begin
                    state_next = ccs_pkg::S_IDLE;
                end
                else if (sts.cur_status == ccs_pkg::CS_DONE)
                begin
                    state_next = ccs_pkg::S_OK_SCAN;
                end
                else
                begin
                    state_next = ccs_pkg::S_ACT;
                end
            end
            ccs_pkg::S_OK_SCAN:
            begin
                if (sts.scan_open)
                begin
                    state_next = ccs_pkg::S_ACT;
                end
                else if (sts.scan_last)
                begin
                    state_next = ccs_pkg::S_IDLE;
                end
            end
            ccs_pkg::S_ACT:
            begin
                case (sts.cur_status)
                    ccs_pkg::CS_INIT:
                    begin
                        if (sts.out_free)
                        begin
                            state_next = ccs_pkg::S_IDLE;
                        end
                    end
                    ccs_pkg::CS_REPLY:
                    begin
                        if (sts.reply_done)
                        begin
                            state_next = ccs_pkg::S_TO_SCAN;
                        end
                        else
                        begin
                            state_next = ccs_pkg::S_IDLE;
                        end
                    end
                    default: state_next = ccs_pkg::S_IDLE;
                endcase
            end
            ccs_pkg::S_TO_SCAN:
            begin
                if (sts.scan_open || sts.scan_last)
                begin
                    state_next = ccs_pkg::S_IDLE;
                end
            end
            default: state_next = ccs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ccs_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            ccs_pkg::S_DECODE:
            begin
                case (sts.kind)
                    ccs_pkg::CMD_SET:     cmd.tbl_wr = 1'b1;
                    ccs_pkg::CMD_CONFIRM: cmd.scan_init_zero = 1'b1;
                    ccs_pkg::CMD_POLL:    cmd.start_proc = sts.changed && !sts.blocked;
                    default:              cmd = '0;
                endcase
            end
            ccs_pkg::S_CONF:
            begin
                cmd.use_scan = 1'b1;
                if (sts.conf_hit)
                begin
                    cmd.conf_set_ok = 1'b1;
                end
                else if (!sts.scan_last)
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ccs_pkg::S_START_SCAN, ccs_pkg::S_OK_SCAN, ccs_pkg::S_TO_SCAN:
            begin
                cmd.use_scan = 1'b1;
                if (sts.scan_open)
                begin
                    cmd.set_cur_scan = 1'b1;
                end
                else if (sts.scan_last)
                begin
                    cmd.clr_cur = 1'b1;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ccs_pkg::S_WINDOW:
            begin
                if (sts.cur_valid && sts.window_expired)
                begin
                    cmd.clr_cur = 1'b1;
                end
                else if (sts.cur_valid && sts.cur_status == ccs_pkg::CS_DONE)
                begin
                    cmd.scan_init_cur = 1'b1;
                end
            end
            ccs_pkg::S_ACT:
            begin
                case (sts.cur_status)
                    ccs_pkg::CS_INIT:  cmd.emit = sts.out_free;
                    ccs_pkg::CS_GUARD: cmd.to_reply = sts.guard_done;
                    ccs_pkg::CS_REPLY:
                    begin
                        cmd.to_init       = sts.reply_done;
                        cmd.scan_init_cur = sts.reply_done;
                    end
                    default: cmd = '0;
                endcase
            end
            default: cmd = '0;
        endcase
    end

endmodule

[rtl/core/ccs_datapath.sv]
module ccs_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [ccs_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ccs_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  ccs_pkg::ccs_cmd_t                    cmd,
    output ccs_pkg::ccs_sts_t                    sts
);

    localparam int CW = ccs_pkg::CIDX_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(ccs_pkg::CLIENTS - 1);

    // configuration
    logic [7:0]  own_addr_reg;
    logic [7:0]  guard_reg;
    logic [15:0] reply_reg;
    logic [15:0] window_reg;

    // latched request
    logic [1:0]  kind_reg;
    logic [15:0] now_reg;
    logic [1:0]  in_state_reg;
    logic [7:0]  peer_reg;
    logic [3:0]  entry_reg;

    // process state
    logic [7:0]    addr_tbl_reg [ccs_pkg::CLIENTS];
    ccs_pkg::cst_t status_reg   [ccs_pkg::CLIENTS];
    logic [15:0]   rtime_reg    [ccs_pkg::CLIENTS];
    logic          cur_valid_reg;
    logic [CW-1:0] cur_idx_reg;
    logic [CW-1:0] sidx_reg;
    logic [CW-1:0] scnt_reg;
    logic [15:0]   change_time_reg;
    logic [2:0]    last_seen_reg;
    logic [1:0]    sent_state_reg;

    logic                            m_tvalid_reg;
    logic [ccs_pkg::OUT_DATA_W-1:0]  m_tdata_reg;

    logic [CW-1:0]  rd_idx;
    ccs_pkg::cst_t  rd_status;
    logic [7:0]     rd_addr;
    logic [15:0]    rd_rtime;
    logic [CW-1:0]  cur_plus1;
    logic [CW-1:0]  sidx_plus1;
    logic [7:0]     guard_elapsed;
    logic [15:0]    reply_elapsed;
    logic [15:0]    window_elapsed;
    logic           entry_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= ccs_pkg::OWN_ADDR_RST;
            guard_reg    <= ccs_pkg::GUARD_RST;
            reply_reg    <= ccs_pkg::REPLY_RST;
            window_reg   <= ccs_pkg::WINDOW_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ccs_pkg::REG_OWN_ADDR: own_addr_reg <= cfg_data[7:0];
                ccs_pkg::REG_GUARD:    guard_reg    <= cfg_data[7:0];
                ccs_pkg::REG_REPLY:    reply_reg    <= cfg_data;
                ccs_pkg::REG_WINDOW:   window_reg   <= cfg_data;
                default:               own_addr_reg <= own_addr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg     <= s_tuser;
            now_reg      <= s_tdata[15:0];
            in_state_reg <= s_tdata[17:16];
            peer_reg     <= s_tdata[25:18];
            entry_reg    <= s_tdata[29:26];
        end
    end

    // single table read port, shared between the scan pointer and the current client
    assign rd_idx    = cmd.use_scan ? sidx_reg : cur_idx_reg;
    assign rd_status = status_reg[rd_idx];
    assign rd_addr   = addr_tbl_reg[rd_idx];
    assign rd_rtime  = rtime_reg[rd_idx];

    assign cur_plus1  = (cur_idx_reg == LAST_IDX) ? '0 : cur_idx_reg + 1'b1;
    assign sidx_plus1 = (sidx_reg == LAST_IDX) ? '0 : sidx_reg + 1'b1;

    assign guard_elapsed  = now_reg[7:0] - rd_rtime[7:0];
    assign reply_elapsed  = now_reg - rd_rtime;
    assign window_elapsed = now_reg - change_time_reg;
    assign entry_in_range = 32'(entry_reg) < 32'(ccs_pkg::CLIENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ccs_pkg::CLIENTS; i++)
            begin
                addr_tbl_reg[i] <= ccs_pkg::ADDR_INVALID;
            end
        end
        else if (cmd.tbl_wr && entry_in_range)
        begin
            addr_tbl_reg[CW'(entry_reg)] <= peer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ccs_pkg::CLIENTS; i++)
            begin
                status_reg[i] <= ccs_pkg::CS_SKIP;
            end
        end
        else if (cmd.start_proc)
        begin
            for (int i = 0; i < ccs_pkg::CLIENTS; i++)
            begin
                status_reg[i] <= (addr_tbl_reg[i] != ccs_pkg::ADDR_INVALID) ?
                                 ccs_pkg::CS_INIT : ccs_pkg::CS_SKIP;
            end
        end
        else if (cmd.conf_set_ok)
        begin
            status_reg[sidx_reg] <= ccs_pkg::CS_DONE;
        end
        else if (cmd.emit)
        begin
            status_reg[cur_idx_reg] <= ccs_pkg::CS_GUARD;
        end
        else if (cmd.to_reply)
        begin
            status_reg[cur_idx_reg] <= ccs_pkg::CS_REPLY;
        end
        else if (cmd.to_init)
        begin
            status_reg[cur_idx_reg] <= ccs_pkg::CS_INIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit || cmd.to_reply)
        begin
            rtime_reg[cur_idx_reg] <= now_reg;
        end
        if (cmd.start_proc)
        begin
            change_time_reg <= now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            cur_idx_reg    <= '0;
            sidx_reg       <= '0;
            scnt_reg       <= '0;
            last_seen_reg  <= ccs_pkg::LAST_SEEN_RST;
            sent_state_reg <= '0;
        end
        else
        begin
            if (cmd.start_proc)
            begin
                last_seen_reg  <= {1'b0, in_state_reg};
                sent_state_reg <= in_state_reg;
            end
            if (cmd.start_proc || cmd.scan_init_zero)
            begin
                sidx_reg <= '0;
                scnt_reg <= '0;
            end
            else if (cmd.scan_init_cur)
            begin
                sidx_reg <= cur_plus1;
                scnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                sidx_reg <= sidx_plus1;
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (cmd.set_cur_scan)
            begin
                cur_valid_reg <= 1'b1;
                cur_idx_reg   <= sidx_reg;
            end
            else if (cmd.clr_cur)
            begin
                cur_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tdata_reg <= {6'd0, sent_state_reg, rd_addr, own_addr_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        sts                = '0;
        sts.kind           = kind_reg;
        sts.changed        = {1'b0, in_state_reg} != last_seen_reg;
        sts.blocked        = cur_valid_reg && (rd_status == ccs_pkg::CS_GUARD);
        sts.cur_valid      = cur_valid_reg;
        sts.cur_status     = rd_status;
        sts.window_expired = window_elapsed >= window_reg;
        sts.guard_done     = guard_elapsed >= guard_reg;
        sts.reply_done     = reply_elapsed >= reply_reg;
        sts.scan_open      = (rd_status != ccs_pkg::CS_SKIP) && (rd_status != ccs_pkg::CS_DONE);
        sts.scan_last      = scnt_reg == LAST_IDX;
        sts.conf_hit       = (rd_status inside {ccs_pkg::CS_GUARD, ccs_pkg::CS_REPLY})
                             && (rd_addr == peer_reg) && (in_state_reg == sent_state_reg);
        sts.out_free       = !m_tvalid_reg || m_tready;
    end

endmodule

[rtl/core/client_confirm_sequencer.sv]
// Switch-state request sequencer. Each poll (tuser 0) may send one request
// {sender, receiver, state} on the master side; confirmations (tuser 1) mark a
// client done, and tuser 2 writes a client table slot. One request is handled at
// a time. Confirmations and polls may walk the status table one slot per cycle
// through its single read port; a poll that sends also waits for the output
// register to drain. A finished request sits in the output register while the
// next one is taken.
module client_confirm_sequencer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] now_ms, [17:16] input_state, [25:18] peer_addr, [29:26] entry_index
    input  logic [ccs_pkg::IN_DATA_W-1:0]      s_tdata,
    // [1:0] command
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] sender_addr, [15:8] receiver_addr, [17:16] switch_state
    output logic [ccs_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ccs_pkg::ccs_cmd_t cmd;
    ccs_pkg::ccs_sts_t sts;

    ccs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef NO_ASSERTIONS
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("request loaded over a pending output");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("loaded request not presented");

    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !(cmd.emit || cmd.scan_step || cmd.start_proc))
        else $error("request accepted while work in progress");

    a_cur_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_cur_scan |-> sts.scan_open)
        else $error("current client moved to a closed slot");
`endif

endmodule
